// ----- hw/rtl/serc_pkg.sv -----
`timescale 1ns / 1ps

package serc_pkg;

  // Input item kinds
  localparam logic [1:0] KIND_CMD  = 2'd0;
  localparam logic [1:0] KIND_RX   = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  // Result item kinds
  localparam logic [1:0] OUT_TX     = 2'd0;
  localparam logic [1:0] OUT_DONE   = 2'd1;
  localparam logic [1:0] OUT_NOTICE = 2'd2;

  // Outcome codes
  localparam logic [2:0] OC_OK         = 3'd0;
  localparam logic [2:0] OC_REPLY_TO   = 3'd1;
  localparam logic [2:0] OC_LINK_DOWN  = 3'd2;
  localparam logic [2:0] OC_CSUM_RETRY = 3'd3;
  localparam logic [2:0] OC_ACK_RETRY  = 3'd4;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_ACK_TO   = 2'd0;
  localparam logic [1:0] REG_REPLY_TO = 2'd1;
  localparam logic [1:0] REG_RETRY    = 2'd2;

  localparam int unsigned PaddrW = 4;

  localparam logic [15:0] AckToReset   = 16'd20;
  localparam logic [15:0] ReplyToReset = 16'd100;
  localparam logic [3:0]  RetryReset   = 4'd3;

  localparam logic [7:0] AckByte   = 8'h40;
  localparam logic [7:0] CsumSeed  = 8'h40;
  localparam logic [7:0] CsumInv   = 8'hFF;
  localparam logic [2:0] LastByte  = 3'd5;

endpackage

// ----- hw/rtl/serc_cmd_if.sv -----
`timescale 1ns / 1ps

interface serc_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  reg_low;
  logic [7:0]  reg_high;
  logic [15:0] target_address;
  logic [7:0]  opcode;
  logic [7:0]  rx_value;

  modport source (
    output valid, kind, reg_low, reg_high, target_address, opcode, rx_value,
    input  ready
  );
  modport sink (
    input  valid, kind, reg_low, reg_high, target_address, opcode, rx_value,
    output ready
  );
endinterface

// ----- hw/rtl/serc_res_if.sv -----
`timescale 1ns / 1ps

interface serc_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] tx_value;
  logic       tx_last;
  logic [7:0] reply_value;
  logic [2:0] outcome;

  modport source (
    output valid, out_kind, tx_value, tx_last, reply_value, outcome,
    input  ready
  );
  modport sink (
    input  valid, out_kind, tx_value, tx_last, reply_value, outcome,
    output ready
  );
endinterface

// ----- hw/rtl/serial_command_retry_engine.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Carries
// cmd_i     in   valid/ready    command, received byte or tick
// res_o     out  valid/ready    transmit byte, finish or retry notice
// APB       in   psel/penable   ack/reply timeout and retry limit registers
//
// An item is fully processed in the cycle it is accepted; its results (up to
// seven: one head result plus a six-byte frame) leave res_o one per cycle.
// A new item is taken while the last result of the previous one transfers,
// so single-result items stream at one per cycle. Reset clears the engine
// state, loads the register defaults; the link-failed flag stays set until
// reset. A stall on res_o holds the current result and blocks cmd_i.

module serial_command_retry_engine (
  input logic                          clk_i,
  input logic                          rst_ni,
  serc_cmd_if.sink                     cmd_i,
  serc_res_if.source                   res_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [serc_pkg::PaddrW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import serc_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ACK,
    PH_REPLY
  } phase_e;

  // Configuration registers
  logic [15:0] ack_to_q, reply_to_q;
  logic [3:0]  retry_limit_q;

  // Engine state
  phase_e      phase_q, phase_d;
  logic [47:0] frame_store_q, frame_store_d;
  logic [3:0]  retries_left_q, retries_left_d;
  logic        timeout_seen_q, timeout_seen_d;
  logic [15:0] tick_timer_q, tick_timer_d;
  logic        link_failed_q, link_failed_d;

  // Result burst: an optional head result followed by an optional frame
  logic        head_q, head_d;
  logic [1:0]  head_kind_q, head_kind_d;
  logic        head_last_q, head_last_d;
  logic [7:0]  head_reply_q, head_reply_d;
  logic [2:0]  head_outcome_q, head_outcome_d;
  logic        frame_q, frame_d;
  logic [2:0]  idx_q;

  logic        busy, last_res, in_xfer, out_xfer, cfg_wr;
  logic [15:0] timer_inc;
  logic [7:0]  csum;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_ACK_TO:   prdata = {16'd0, ack_to_q};
      REG_REPLY_TO: prdata = {16'd0, reply_to_q};
      REG_RETRY:    prdata = {28'd0, retry_limit_q};
      default:      prdata = 32'd0;
    endcase
  end

  // Burst bookkeeping: the last result is the head alone, or frame byte six.
  assign busy     = head_q || frame_q;
  assign last_res = head_q ? !frame_q : (idx_q == LastByte);
  assign out_xfer = res_o.valid && res_o.ready;
  assign cmd_i.ready = !busy || (res_o.ready && last_res);
  assign in_xfer  = cmd_i.valid && cmd_i.ready;

  assign timer_inc = (tick_timer_q == 16'hFFFF) ? tick_timer_q : tick_timer_q + 16'd1;

  // Checksum over the five payload bytes, then the zero checksum slot.
  always_comb begin
    logic [7:0] s;
    s = CsumSeed;
    s = (s ^ cmd_i.reg_low) + 8'd1;
    s = (s ^ cmd_i.reg_high) + 8'd1;
    s = (s ^ cmd_i.target_address[7:0]) + 8'd1;
    s = (s ^ cmd_i.target_address[15:8]) + 8'd1;
    s = (s ^ cmd_i.opcode) + 8'd1;
    s = s + 8'd1;
    csum = (s - 8'd1) ^ CsumInv;
  end

  // Next state and burst for the item at the cmd_i port.
  always_comb begin
    phase_d        = phase_q;
    frame_store_d  = frame_store_q;
    retries_left_d = retries_left_q;
    timeout_seen_d = timeout_seen_q;
    tick_timer_d   = tick_timer_q;
    link_failed_d  = link_failed_q;
    head_d         = 1'b0;
    head_kind_d    = OUT_TX;
    head_last_d    = 1'b0;
    head_reply_d   = 8'd0;
    head_outcome_d = OC_OK;
    frame_d        = 1'b0;

    case (cmd_i.kind)
      KIND_CMD: begin
        if (phase_q == PH_IDLE) begin
          if (link_failed_q) begin
            head_d         = 1'b1;
            head_kind_d    = OUT_DONE;
            head_outcome_d = OC_LINK_DOWN;
          end else begin
            frame_store_d  = {csum, cmd_i.opcode, cmd_i.target_address,
                              cmd_i.reg_high, cmd_i.reg_low};
            timeout_seen_d = 1'b0;
            tick_timer_d   = 16'd0;
            if (retry_limit_q == 4'd0) begin
              retries_left_d = 4'd0;
              phase_d        = PH_REPLY;
            end else begin
              frame_d        = 1'b1;
              retries_left_d = retry_limit_q - 4'd1;
              phase_d        = PH_ACK;
            end
          end
        end
      end
      KIND_RX: begin
        case (phase_q)
          PH_ACK: begin
            tick_timer_d = 16'd0;
            if (!timeout_seen_q && cmd_i.rx_value == AckByte) begin
              phase_d = PH_REPLY;
            end else begin
              head_d         = 1'b1;
              head_kind_d    = OUT_NOTICE;
              head_outcome_d = timeout_seen_q ? OC_ACK_RETRY : OC_CSUM_RETRY;
              if (retries_left_q != 4'd0) begin
                frame_d        = 1'b1;
                retries_left_d = retries_left_q - 4'd1;
                timeout_seen_d = 1'b0;
              end else begin
                phase_d = PH_REPLY;
              end
            end
          end
          PH_REPLY: begin
            head_d       = 1'b1;
            head_kind_d  = OUT_DONE;
            head_reply_d = cmd_i.rx_value;
            phase_d      = PH_IDLE;
            tick_timer_d = 16'd0;
          end
          default: ;
        endcase
      end
      KIND_TICK: begin
        case (phase_q)
          PH_ACK: begin
            if (timer_inc >= ack_to_q) begin
              head_d         = 1'b1;
              head_kind_d    = OUT_TX;
              head_last_d    = 1'b1;
              timeout_seen_d = 1'b1;
              tick_timer_d   = 16'd0;
            end else begin
              tick_timer_d = timer_inc;
            end
          end
          PH_REPLY: begin
            if (timer_inc >= reply_to_q) begin
              link_failed_d  = 1'b1;
              head_d         = 1'b1;
              head_kind_d    = OUT_DONE;
              head_outcome_d = OC_REPLY_TO;
              phase_d        = PH_IDLE;
              tick_timer_d   = 16'd0;
            end else begin
              tick_timer_d = timer_inc;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_to_q       <= AckToReset;
      reply_to_q     <= ReplyToReset;
      retry_limit_q  <= RetryReset;
      phase_q        <= PH_IDLE;
      frame_store_q  <= 48'd0;
      retries_left_q <= 4'd0;
      timeout_seen_q <= 1'b0;
      tick_timer_q   <= 16'd0;
      link_failed_q  <= 1'b0;
      head_q         <= 1'b0;
      head_kind_q    <= OUT_TX;
      head_last_q    <= 1'b0;
      head_reply_q   <= 8'd0;
      head_outcome_q <= OC_OK;
      frame_q        <= 1'b0;
      idx_q          <= 3'd0;
    end else begin
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_ACK_TO:   ack_to_q      <= pwdata[15:0];
          REG_REPLY_TO: reply_to_q    <= pwdata[15:0];
          REG_RETRY:    retry_limit_q <= pwdata[3:0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        // Commit the item and load its burst over whatever just finished.
        phase_q        <= phase_d;
        frame_store_q  <= frame_store_d;
        retries_left_q <= retries_left_d;
        timeout_seen_q <= timeout_seen_d;
        tick_timer_q   <= tick_timer_d;
        link_failed_q  <= link_failed_d;
        head_q         <= head_d;
        head_kind_q    <= head_kind_d;
        head_last_q    <= head_last_d;
        head_reply_q   <= head_reply_d;
        head_outcome_q <= head_outcome_d;
        frame_q        <= frame_d;
        idx_q          <= 3'd0;
      end else if (out_xfer) begin
        // Drop the head first, then advance through the frame bytes.
        if (head_q) begin
          head_q <= 1'b0;
        end else if (idx_q == LastByte) begin
          frame_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 3'd1;
        end
      end
    end
  end

  assign res_o.valid       = busy;
  assign res_o.out_kind    = head_q ? head_kind_q : OUT_TX;
  assign res_o.tx_value    = head_q ? 8'd0 : frame_store_q[{idx_q, 3'b000} +: 8];
  assign res_o.tx_last     = head_q ? head_last_q : (idx_q == LastByte);
  assign res_o.reply_value = head_q ? head_reply_q : 8'd0;
  assign res_o.outcome     = head_q ? head_outcome_q : OC_OK;

`ifndef SYNTHESIS
  a_frame_in_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_q |-> phase_q == PH_ACK)
    else $error("frame burst outside ack phase");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_q |-> idx_q <= LastByte)
    else $error("frame byte index out of range");

  a_link_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    link_failed_q |=> link_failed_q)
    else $error("link failure flag cleared");

  a_retries_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_IDLE |-> retries_left_q <= retry_limit_q)
    else $error("retries left exceeds limit");
`endif

endmodule

// ----- tb/serial_command_retry_engine_tb.sv -----
`timescale 1ns / 1ps

module serial_command_retry_engine_tb;
  import serc_pkg::*;

  localparam int QuietCycles = 16;    // settle time after the last result
  localparam int StallLimit  = 4000;  // cycles without any transfer
  localparam int SqueezeLen  = 300;   // long receiver hold-off
  localparam int MaxPrinted  = 20;

  // Engine phases, as the predictor tracks them
  typedef enum logic [1:0] {ENG_IDLE, ENG_ACK, ENG_REPLY} eng_phase_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  reg_low;
    logic [7:0]  reg_high;
    logic [15:0] target_address;
    logic [7:0]  opcode;
    logic [7:0]  rx_value;
  } link_item_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] tx_value;
    logic       tx_last;
    logic [7:0] reply_value;
    logic [2:0] outcome;
  } link_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  serc_cmd_if cmd_if ();
  serc_res_if res_if ();

  serial_command_retry_engine dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Items waiting for the driver, and results the engine still owes
  link_item_t   pending_items[$];
  link_result_t due_results[$];

  // Predictor copy of the engine state and its registers
  eng_phase_e  eng_phase;
  logic [47:0] frame_bytes;
  logic [3:0]  sends_left;
  logic        ack_missed;
  logic [15:0] tick_count;
  logic        link_dead;
  logic [15:0] cfg_ack_to;
  logic [15:0] cfg_reply_to;
  logic [3:0]  cfg_retries;

  // Run statistics
  int frames_sent, null_bytes, retry_notices, replies_ok, reply_timeouts, dead_finishes;
  int items_taken, results_seen, mismatches;

  // Stimulus bookkeeping
  int phase_pushed;
  int tick_budget;
  int src_hold, src_calm, sink_hold, sink_calm;
  int quiet_cycles;
  int squeeze_left;
  bit squeeze_req;

  link_item_t   next_item;
  link_item_t   taken_item;
  link_result_t seen_result;
  link_result_t want_result;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Checking helpers
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MaxPrinted) $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                results_seen, name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Predictor: frame building, ack/retry handling, tick timeouts
  // ---------------------------------------------------------------------------

  task automatic owe_result(logic [1:0] kind, logic [7:0] tx, logic last,
                            logic [7:0] reply, logic [2:0] oc);
    link_result_t r;
    r.out_kind    = kind;
    r.tx_value    = tx;
    r.tx_last     = last;
    r.reply_value = reply;
    r.outcome     = oc;
    due_results.push_back(r);
  endtask

  // Emit the stored six-byte frame as one burst and rearm the ack wait.
  task automatic send_frame_bytes();
    for (int i = 0; i < 6; i++)
      owe_result(OUT_TX, frame_bytes[8*i +: 8], i == LastByte, 8'h00, OC_OK);
    sends_left = sends_left - 4'd1;
    ack_missed = 1'b0;
    tick_count = '0;
    eng_phase  = ENG_ACK;
    frames_sent++;
  endtask

  task automatic enter_reply_wait();
    eng_phase  = ENG_REPLY;
    tick_count = '0;
  endtask

  task automatic advance_engine(link_item_t it);
    logic [7:0] b [6];
    logic [7:0] sum;
    case (it.kind)
      KIND_CMD: begin
        // A command is only taken at rest; busy commands vanish silently.
        if (eng_phase == ENG_IDLE) begin
          if (link_dead) begin
            owe_result(OUT_DONE, 8'h00, 1'b0, 8'h00, OC_LINK_DOWN);
            dead_finishes++;
          end else begin
            b[0] = it.reg_low;
            b[1] = it.reg_high;
            b[2] = it.target_address[7:0];
            b[3] = it.target_address[15:8];
            b[4] = it.opcode;
            b[5] = 8'h00;
            // Running xor-and-increment over all six bytes, checksum slot as zero
            sum = CsumSeed;
            for (int i = 0; i < 6; i++) sum = (sum ^ b[i]) + 8'd1;
            b[5] = (sum - 8'd1) ^ CsumInv;
            frame_bytes = {b[5], b[4], b[3], b[2], b[1], b[0]};
            sends_left  = cfg_retries;
            ack_missed  = 1'b0;
            if (sends_left == 4'd0) enter_reply_wait();
            else send_frame_bytes();
          end
        end
      end
      KIND_RX: begin
        if (eng_phase == ENG_ACK) begin
          if (!ack_missed && it.rx_value == AckByte) begin
            enter_reply_wait();
          end else begin
            // Wrong byte, or an ack that came after a null byte: costs a send.
            owe_result(OUT_NOTICE, 8'h00, 1'b0, 8'h00,
                       ack_missed ? OC_ACK_RETRY : OC_CSUM_RETRY);
            retry_notices++;
            if (sends_left != 4'd0) send_frame_bytes();
            else enter_reply_wait();
          end
        end else if (eng_phase == ENG_REPLY) begin
          owe_result(OUT_DONE, 8'h00, 1'b0, it.rx_value, OC_OK);
          replies_ok++;
          eng_phase  = ENG_IDLE;
          tick_count = '0;
        end
      end
      KIND_TICK: begin
        if (eng_phase != ENG_IDLE) begin
          if (tick_count != 16'hFFFF) tick_count = tick_count + 16'd1;
          if (eng_phase == ENG_ACK) begin
            if (tick_count >= cfg_ack_to) begin
              owe_result(OUT_TX, 8'h00, 1'b1, 8'h00, OC_OK);
              null_bytes++;
              ack_missed = 1'b1;
              tick_count = '0;
            end
          end else if (tick_count >= cfg_reply_to) begin
            // Reply never came: the link stays down until reset.
            link_dead = 1'b1;
            owe_result(OUT_DONE, 8'h00, 1'b0, 8'h00, OC_REPLY_TO);
            reply_timeouts++;
            eng_phase  = ENG_IDLE;
            tick_count = '0;
          end
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------

  // Mostly no gap, some short ones, a few long; now and then a calm stretch.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) calm = $urandom_range(20, 80);
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Randomize every field so unused ones toggle too.
  function automatic link_item_t make_item(logic [1:0] kind);
    link_item_t it;
    it.kind           = kind;
    it.reg_low        = 8'($urandom);
    it.reg_high       = 8'($urandom);
    it.target_address = 16'($urandom);
    it.opcode         = 8'($urandom);
    it.rx_value       = 8'($urandom);
    return it;
  endfunction

  task automatic push_item(link_item_t it);
    pending_items.push_back(it);
    phase_pushed++;
  endtask

  task automatic push_command(logic [7:0] lo, logic [7:0] hi, logic [15:0] addr,
                              logic [7:0] op);
    link_item_t it;
    it = make_item(KIND_CMD);
    it.reg_low        = lo;
    it.reg_high       = hi;
    it.target_address = addr;
    it.opcode         = op;
    push_item(it);
  endtask

  // Command with every payload field random.
  task automatic push_random_command();
    push_command(8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic push_rx(logic [7:0] value);
    link_item_t it;
    it = make_item(KIND_RX);
    it.rx_value = value;
    push_item(it);
  endtask

  // Ticks draw on a per-phase budget so that no reply wait can time out.
  task automatic push_ticks(int n);
    repeat (n) begin
      if (tick_budget > 0) begin
        tick_budget--;
        push_item(make_item(KIND_TICK));
      end
    end
  endtask

  // Any kind, the unused code included.
  task automatic push_noise();
    link_item_t it;
    it = make_item(2'($urandom));
    if (it.kind == KIND_TICK) begin
      if (tick_budget > 0) tick_budget--;
      else it.kind = 2'd3;
    end
    push_item(it);
  endtask

  // One command with a random run of bad bytes, late acks and timeouts,
  // then the ack and the reply byte.
  task automatic push_exchange(int tick_span);
    int         rounds;
    logic [7:0] bad;
    push_random_command();
    rounds = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 17) : $urandom_range(0, 2);
    repeat (rounds) begin
      case ($urandom_range(0, 3))
        0, 1: begin
          bad = 8'($urandom);
          if (bad == AckByte) bad = 8'h00;
          push_rx(bad);
        end
        2: begin
          push_ticks($urandom_range(1, tick_span));
          push_rx(($urandom_range(0, 3) == 0) ? 8'($urandom) : AckByte);
        end
        default: begin
          push_ticks($urandom_range(0, 1));
          push_rx(AckByte);
        end
      endcase
      if ($urandom_range(0, 7) == 0) push_noise();
    end
    push_rx(AckByte);
    push_ticks($urandom_range(0, 3));
    push_rx(8'($urandom));
    if ($urandom_range(0, 5) == 0) push_noise();
  endtask

  // Wait at falling edges, where every driver update has landed.
  task automatic wait_for_quiet();
    @(negedge clk_i);
    while (pending_items.size() != 0 || cmd_if.valid || due_results.size() != 0)
      @(negedge clk_i);
    repeat (QuietCycles) @(negedge clk_i);
  endtask

  // Feed acks and replies until the predictor is back at rest.
  task automatic settle_engine();
    wait_for_quiet();
    while (eng_phase != ENG_IDLE) begin
      push_rx((eng_phase == ENG_ACK) ? AckByte : 8'($urandom));
      wait_for_quiet();
    end
  endtask

  task automatic run_random(int count, int tick_span, int budget, bit squeeze);
    phase_pushed = 0;
    tick_budget  = budget;
    while (phase_pushed < count) push_exchange(tick_span);
    // Hold the receiver off while the whole phase sits in front of the block.
    if (squeeze) squeeze_req = 1'b1;
    settle_engine();
  endtask

  // Setup then access; the register takes the value at the access edge.
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    logic [31:0] want_rd;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ACK_TO: begin
        cfg_ack_to = value[15:0];
        want_rd    = {16'd0, value[15:0]};
      end
      REG_REPLY_TO: begin
        cfg_reply_to = value[15:0];
        want_rd      = {16'd0, value[15:0]};
      end
      REG_RETRY: begin
        cfg_retries = value[3:0];
        want_rd     = {28'd0, value[3:0]};
      end
      default: want_rd = 32'd0;
    endcase
    @(negedge clk_i);
    // Read back through the still-addressed register.
    if (!pready || prdata !== want_rd)
      report_mismatch($sformatf("register %0d reads 0x%0h want 0x%0h",
                                idx, prdata, want_rd));
  endtask

  task automatic set_timing(logic [15:0] ack_to, logic [15:0] reply_to, logic [3:0] retries);
    write_reg(REG_ACK_TO, 32'(ack_to));
    write_reg(REG_REPLY_TO, 32'(reply_to));
    write_reg(REG_RETRY, 32'(retries));
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer the next pending item; hold it until the transfer.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!cmd_if.valid || cmd_if.ready) begin
        if (src_hold != 0) begin
          src_hold--;
          cmd_if.valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          next_item = pending_items.pop_front();
          cmd_if.kind           <= next_item.kind;
          cmd_if.reg_low        <= next_item.reg_low;
          cmd_if.reg_high       <= next_item.reg_high;
          cmd_if.target_address <= next_item.target_address;
          cmd_if.opcode         <= next_item.opcode;
          cmd_if.rx_value       <= next_item.rx_value;
          cmd_if.valid          <= 1'b1;
          src_hold = pick_gap(src_calm);
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus the long hold-off while a squeeze runs.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) sink_hold = pick_gap(sink_calm);
      else if (sink_hold != 0) sink_hold--;
      res_if.ready <= (sink_hold == 0) && (squeeze_left == 0);
    end
  end

  // Count the long hold-off in its own process.
  always @(posedge clk_i) begin
    if (squeeze_req) begin
      squeeze_left <= SqueezeLen;
      squeeze_req  <= 1'b0;
    end else if (squeeze_left != 0) begin
      squeeze_left <= squeeze_left - 1;
    end
  end

  // Monitor: predict on each input transfer, then check each result transfer
  // against the oldest owed result. Both in one process, so same-edge order
  // between the two channels cannot matter.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cmd_if.valid && cmd_if.ready) begin
        taken_item.kind           = cmd_if.kind;
        taken_item.reg_low        = cmd_if.reg_low;
        taken_item.reg_high       = cmd_if.reg_high;
        taken_item.target_address = cmd_if.target_address;
        taken_item.opcode         = cmd_if.opcode;
        taken_item.rx_value       = cmd_if.rx_value;
        advance_engine(taken_item);
        items_taken++;
      end
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        seen_result.out_kind    = res_if.out_kind;
        seen_result.tx_value    = res_if.tx_value;
        seen_result.tx_last     = res_if.tx_last;
        seen_result.reply_value = res_if.reply_value;
        seen_result.outcome     = res_if.outcome;
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing owed (kind %0d)",
                                    results_seen, seen_result.out_kind));
        end else begin
          want_result = due_results.pop_front();
          check_field("out_kind", 8'(seen_result.out_kind), 8'(want_result.out_kind));
          check_field("tx_value", seen_result.tx_value, want_result.tx_value);
          check_field("tx_last", 8'(seen_result.tx_last), 8'(want_result.tx_last));
          check_field("reply_value", seen_result.reply_value, want_result.reply_value);
          check_field("outcome", 8'(seen_result.outcome), 8'(want_result.outcome));
        end
      end
    end
  end

  // Watchdog: drop the run if no transfer of any kind happens for too long.
  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
        (psel && penable))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("%0t watchdog: no transfer for %0d cycles, %0d results owed",
               $time, quiet_cycles, due_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of phases
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni                = 1'b0;
    cmd_if.valid          = 1'b0;
    cmd_if.kind           = KIND_CMD;
    cmd_if.reg_low        = '0;
    cmd_if.reg_high       = '0;
    cmd_if.target_address = '0;
    cmd_if.opcode         = '0;
    cmd_if.rx_value       = '0;
    res_if.ready          = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    squeeze_req           = 1'b0;
    squeeze_left          = 0;

    eng_phase    = ENG_IDLE;
    frame_bytes  = '0;
    sends_left   = '0;
    ack_missed   = 1'b0;
    tick_count   = '0;
    link_dead    = 1'b0;
    cfg_ack_to   = AckToReset;
    cfg_reply_to = ReplyToReset;
    cfg_retries  = RetryReset;
    tick_budget  = 1000;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part at the reset register values.
    push_item(make_item(KIND_TICK));               // tick at rest: ignored
    push_rx(AckByte);                              // byte at rest: ignored
    push_item(make_item(2'd3));                    // unused kind: ignored
    push_command(8'h00, 8'h00, 16'h0000, 8'h00);
    push_command(8'hFF, 8'hFF, 16'hFFFF, 8'hFF);   // busy: dropped
    push_rx(AckByte);
    push_rx(8'h00);
    push_command(8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
    push_rx(8'hFF);                                // bad ack: notice and resend
    push_rx(AckByte);
    push_item(make_item(KIND_TICK));
    push_rx(8'hFF);
    push_command(8'h5A, 8'hA5, 16'h1234, 8'hC3);
    push_rx(8'h41);
    push_rx(8'h3F);
    push_rx(8'h00);                                // sends used up: go to reply
    push_rx(8'h80);
    settle_engine();

    // Shortest ack timeout, longest reply timeout, one send per command.
    set_timing(16'd1, 16'hFFFF, 4'd1);
    run_random(95, 3, 65000, 1'b0);

    // Most sends; squeeze the receiver while the phase is queued.
    set_timing(16'($urandom_range(2, 8)), 16'd400, 4'd15);
    run_random(105, 10, 390, 1'b1);

    // No frame at all: commands go straight to the reply wait.
    set_timing(16'd3, 16'd200, 4'd0);
    run_random(70, 3, 190, 1'b0);

    // Zero ack timeout fires on the first tick.
    set_timing(16'd0, 16'd150, 4'd2);
    run_random(75, 2, 140, 1'b0);

    // Long ack timeout: one full wait until the null byte.
    set_timing(16'd30, 16'hFFFF, 4'd1);
    tick_budget = 100;
    push_random_command();
    push_ticks(30);
    push_rx(AckByte);
    push_rx(8'($urandom));
    settle_engine();

    // Zero reply timeout: fail the link, then every command finishes at once.
    write_reg(REG_REPLY_TO, 32'd0);
    tick_budget = 1000;
    push_random_command();
    push_rx(AckByte);
    push_ticks(1);
    run_random(25, 3, 1000, 1'b0);

    wait_for_quiet();
    if (due_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", due_results.size()));

    $display("Run: %0d items in, %0d results out; %0d frames, %0d null bytes, %0d notices",
             items_taken, results_seen, frames_sent, null_bytes, retry_notices);
    $display("     %0d replies, %0d reply timeouts, %0d link-down finishes, %0d mismatches",
             replies_ok, reply_timeouts, dead_finishes, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
